// ----- design/msprd_pkg.sv -----
// Shared types and constants for the MSP response frame deframer.
// No dependencies; used by every module of the block.
package msprd_pkg;

  localparam logic [7:0] ByteDollar = 8'h24;
  localparam logic [7:0] ByteM      = 8'h4D;
  localparam logic [7:0] ByteBang   = 8'h21;

  localparam logic [7:0] MaxPayloadReset = 8'd244;

  localparam logic [2:0] PhHunt    = 3'd0;
  localparam logic [2:0] PhDir     = 3'd1;
  localparam logic [2:0] PhLen     = 3'd2;
  localparam logic [2:0] PhCmd     = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;
  localparam logic [2:0] PhCsum    = 3'd5;
  localparam logic [2:0] PhErrWait = 3'd6;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StChecksum = 2'd1;
  localparam logic [1:0] StErrReply = 2'd2;
  localparam logic [1:0] StOverflow = 2'd3;

  localparam logic KindPayload = 1'b0;
  localparam logic KindEnd     = 1'b1;

  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);
  localparam int QueueCw    = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic       kind;
    logic [7:0] command;
    logic [7:0] data;
    logic [7:0] index;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [QueueCw-1:0] count;
  } q_stat_t;

endpackage

// ----- design/msprd_front.sv -----
// Front end: takes received bytes, runs the frame state machine and
// pushes classified results into the queue. Holds the max_payload register.
// Depends on msprd_pkg.
module msprd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            rx_byte,
  input  logic                  cfg_write,
  input  logic [7:0]            cfg_data,
  input  logic                  queue_full,
  output logic                  push,
  output msprd_pkg::res_t       push_res
);

  logic [7:0] max_payload;
  logic [2:0] phase, phase_next;
  logic [7:0] previous_byte;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] frame_command, frame_command_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] payload_count, payload_count_next;
  logic       error_direction, error_direction_next;
  logic       accept;
  logic       emit;
  msprd_pkg::res_t res;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  always_comb begin
    phase_next           = phase;
    frame_length_next    = frame_length;
    frame_command_next   = frame_command;
    running_xor_next     = running_xor;
    payload_count_next   = payload_count;
    error_direction_next = error_direction;
    emit                 = 1'b0;
    res                  = '0;
    if (rx_byte == msprd_pkg::ByteM && previous_byte == msprd_pkg::ByteDollar) begin
      phase_next = msprd_pkg::PhDir;
    end else begin
      case (phase)
        msprd_pkg::PhDir: begin
          error_direction_next = (rx_byte == msprd_pkg::ByteBang);
          phase_next = msprd_pkg::PhLen;
        end
        msprd_pkg::PhLen: begin
          frame_length_next = rx_byte;
          running_xor_next  = rx_byte;
          if (rx_byte > max_payload) begin
            emit        = 1'b1;
            res.kind    = msprd_pkg::KindEnd;
            res.status  = msprd_pkg::StOverflow;
            res.last    = 1'b1;
            phase_next  = msprd_pkg::PhHunt;
          end else begin
            phase_next = msprd_pkg::PhCmd;
          end
        end
        msprd_pkg::PhCmd: begin
          frame_command_next = rx_byte;
          running_xor_next   = running_xor ^ rx_byte;
          payload_count_next = '0;
          if (error_direction) begin
            phase_next = msprd_pkg::PhErrWait;
          end else if (frame_length == 8'd0) begin
            phase_next = msprd_pkg::PhCsum;
          end else begin
            phase_next = msprd_pkg::PhPayload;
          end
        end
        msprd_pkg::PhPayload: begin
          emit               = 1'b1;
          res.kind           = msprd_pkg::KindPayload;
          res.command        = frame_command;
          res.data           = rx_byte;
          res.index          = payload_count;
          res.status         = msprd_pkg::StOk;
          res.last           = 1'b0;
          running_xor_next   = running_xor ^ rx_byte;
          payload_count_next = payload_count + 8'd1;
          if (payload_count_next == frame_length) begin
            phase_next = msprd_pkg::PhCsum;
          end
        end
        msprd_pkg::PhCsum: begin
          emit        = 1'b1;
          res.kind    = msprd_pkg::KindEnd;
          res.command = frame_command;
          res.status  = (rx_byte == running_xor) ? msprd_pkg::StOk : msprd_pkg::StChecksum;
          res.last    = 1'b1;
          phase_next  = msprd_pkg::PhHunt;
        end
        msprd_pkg::PhErrWait: begin
          emit        = 1'b1;
          res.kind    = msprd_pkg::KindEnd;
          res.command = frame_command;
          res.status  = msprd_pkg::StErrReply;
          res.last    = 1'b1;
          phase_next  = msprd_pkg::PhHunt;
        end
        default: begin
          phase_next = msprd_pkg::PhHunt;
        end
      endcase
    end
  end

  assign push     = accept && emit;
  assign push_res = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload     <= msprd_pkg::MaxPayloadReset;
      phase           <= msprd_pkg::PhHunt;
      previous_byte   <= '0;
      frame_length    <= '0;
      frame_command   <= '0;
      running_xor     <= '0;
      payload_count   <= '0;
      error_direction <= 1'b0;
    end else begin
      if (cfg_write) begin
        max_payload <= cfg_data;
      end
      if (accept) begin
        phase           <= phase_next;
        previous_byte   <= rx_byte;
        frame_length    <= frame_length_next;
        frame_command   <= frame_command_next;
        running_xor     <= running_xor_next;
        payload_count   <= payload_count_next;
        error_direction <= error_direction_next;
      end
    end
  end

endmodule

// ----- design/msprd_queue.sv -----
// Short result queue between the front end and the output stage.
// Depends on msprd_pkg.
module msprd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  msprd_pkg::res_t       push_res,
  input  logic                  pop,
  output msprd_pkg::res_t       head,
  output msprd_pkg::q_stat_t    stat
);

  msprd_pkg::res_t                  entries [msprd_pkg::QueueDepth];
  logic [msprd_pkg::QueueAw-1:0]    wptr;
  logic [msprd_pkg::QueueAw-1:0]    rptr;
  logic [msprd_pkg::QueueCw-1:0]    count;

  assign stat.count = count;
  assign stat.full  = (count == msprd_pkg::QueueCw'(msprd_pkg::QueueDepth));
  assign stat.empty = (count == '0);
  assign head       = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/msprd_back.sv -----
// Output stage: pulls results from the queue into the output register
// and hands them over on the valid/stall channel. Depends on msprd_pkg.
module msprd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               queue_empty,
  input  msprd_pkg::res_t    head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output msprd_pkg::res_t    out_res
);

  assign pop = !queue_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= !queue_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= head;
    end
  end

endmodule

// ----- design/msprd_response_frame_deframer_top.sv -----
// MSP v1 response frame deframer, top level.
// Instantiates msprd_front, msprd_queue and msprd_back; uses msprd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / rx_byte): one received serial byte
//   per transfer. in_stall rises only when the four-entry result queue is
//   full; otherwise a byte is taken every cycle.
//   Output channel (out_valid / out_stall / kind, command, data, index,
//   status, last): payload bytes tagged with command and index, and one
//   end-of-frame transfer (last = 1) carrying ok, checksum error, error
//   reply or overflow status. Header bytes and bytes between frames give
//   no transfer.
//   Config channel (cfg_valid / cfg_ready / cfg_data): writes max_payload;
//   cfg_ready is always high. Write only while the block is idle.
//   A result is written into the queue by the edge that takes its byte
//   and then moves through the output register before it is presented.
//   Throughput: one byte per cycle, set by the frame FSM, while not stalled.
//   Reset (rst, synchronous): the parser returns to hunting for '$' 'M',
//   max_payload returns to 244 and the queue and output register empty.
//   When the receiver stalls, the output register holds its result, the
//   queue fills, and after four more results in_stall is raised.
module msp_response_frame_deframer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] command,
  output logic [7:0] data,
  output logic [7:0] index,
  output logic [1:0] status,
  output logic       last
);

  logic                  push;
  logic                  pop;
  msprd_pkg::res_t       push_res;
  msprd_pkg::res_t       head;
  msprd_pkg::res_t       out_res;
  msprd_pkg::q_stat_t    q_stat;

  assign cfg_ready = 1'b1;

  msprd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .queue_full (q_stat.full),
    .push       (push),
    .push_res   (push_res)
  );

  msprd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_res (push_res),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  msprd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (q_stat.empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (out_res)
  );

  assign kind    = out_res.kind;
  assign command = out_res.command;
  assign data    = out_res.data;
  assign index   = out_res.index;
  assign status  = out_res.status;
  assign last    = out_res.last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= msprd_pkg::QueueCw'(msprd_pkg::QueueDepth))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_kind_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == last) && (last || status == msprd_pkg::StOk))
    else $error("result kind, last and status disagree");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && q_stat.empty)
    else $error("output not empty after reset");

endmodule
